// ===== rtl/core/swre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swre_pkg;

  localparam int unsigned SEQ_MOD_DEF     = 1024;
  localparam int unsigned WINDOW_DEF      = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  localparam int unsigned TAG_W     = 16;
  localparam int unsigned RETRY_W   = 8;
  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(100);

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_TIMER = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_DATA  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_GAVE_UP = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_PASS_RD,
    ST_PASS_PROC,
    ST_PASS_GIVEUP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic acc;
    logic full;
    logic send_arm;
  } fin_t;

endpackage

`default_nettype wire

// ===== rtl/core/sliding_window_retransmit_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window ARQ sender/receiver. A command is taken when start is high
// and busy is low; its results come out on res_strobe_o, each for exactly
// one cycle, and the receiver cannot stall them. The last result of every
// command is a finish word with last_o set; it shows in the cycle in which
// busy drops, and the next command can already be taken in that cycle.
// Send and data commands go from idle straight to the done state. Timer and
// ack commands walk the retry queue, which sits in a synchronous RAM: each
// entry is read and then processed, with an extra give-up state when an entry
// is both retransmitted and abandoned; each acked entry is read and checked
// before it is popped.
module sliding_window_retransmit_engine #(
  parameter int unsigned SeqMod     = swre_pkg::SEQ_MOD_DEF,
  parameter int unsigned Window     = swre_pkg::WINDOW_DEF,
  parameter int unsigned QueueDepth = swre_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned SeqW      = $clog2(SeqMod)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [SeqW-1:0]             seq_in_i,
  input  wire logic [swre_pkg::TAG_W-1:0]  msg_tag_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [swre_pkg::RETRY_W-1:0] cfg_wdata_i,
  output logic                             res_strobe_o,
  output logic [1:0]                       kind_o,
  output logic [SeqW-1:0]                  seq_out_o,
  output logic [swre_pkg::TAG_W-1:0]       tag_out_o,
  output logic                             accepted_o,
  output logic                             arm_timer_o,
  output logic                             queue_full_o,
  output logic                             last_o
);

  localparam int unsigned ExpW      = SeqW + 1;
  localparam int unsigned IdxW      = $clog2(QueueDepth);
  localparam int unsigned CntW      = $clog2(QueueDepth + 1);
  localparam int unsigned WinCntW   = $clog2(Window + 1);
  localparam int unsigned ScaleInit = SeqMod / Window;
  localparam int unsigned ScaleW    = $clog2(ScaleInit) + 2;
  localparam int unsigned SumW      = SeqW + 2;
  localparam int unsigned TagW      = swre_pkg::TAG_W;
  localparam int unsigned RetW      = swre_pkg::RETRY_W;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
    logic [RetW-1:0] ret;
  } ent_t;

  typedef struct packed {
    logic            valid;
    logic [1:0]      kind;
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
    logic            acc;
    logic            arm;
    logic            full;
    logic            last;
  } res_t;

  function automatic logic [IdxW-1:0] wrap_idx(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = (CntW+1)'(base) + (CntW+1)'(off);
    if (s >= (CntW+1)'(QueueDepth)) begin
      s = s - (CntW+1)'(QueueDepth);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic in_win(input logic [ExpW-1:0] lo, input logic [SeqW-1:0] hi,
                                  input logic [SeqW-1:0] s);
    return (lo <= {1'b0, s}) || ((s < hi) && ({1'b0, hi} < lo));
  endfunction

  // queue RAM
  ent_t            mem [QueueDepth];
  ent_t            rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  ent_t            mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  swre_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SeqW-1:0]    next_seq_q, next_seq_d;
  logic [ExpW-1:0]    exp_q, exp_d;
  logic [ScaleW-1:0]  scale_q, scale_d;
  logic [RetW-1:0]    max_ret_q;
  logic [CntW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    kept_q, kept_d;
  logic [WinCntW-1:0] writes_q, writes_d;
  ent_t               ent_q, ent_d;
  logic [1:0]         cmd_q, cmd_d;
  swre_pkg::fin_t     fin_q, fin_d;
  res_t               res_q, res_d;
  logic [SeqW-1:0]    seq_in_q;

  // window arithmetic
  logic [SumW-1:0] d_sum, d_t1, d_hi;
  logic [SeqW:0]   a_hi;
  logic            pass_tx;
  logic [RetW-1:0] pass_ret;

  always_comb begin
    d_sum = SumW'(exp_q) + SumW'(Window) * SumW'(scale_q);
    d_t1  = (d_sum >= SumW'(2 * SeqMod)) ? d_sum - SumW'(2 * SeqMod) : d_sum;
    d_hi  = (d_t1 >= SumW'(SeqMod)) ? d_t1 - SumW'(SeqMod) : d_t1;
    a_hi  = (SeqW+1)'(rdata_q.seq) + (SeqW+1)'(Window);
    if (a_hi >= (SeqW+1)'(SeqMod)) begin
      a_hi = a_hi - (SeqW+1)'(SeqMod);
    end
    pass_tx  = (rdata_q.ret != '0) && (writes_q < WinCntW'(Window));
    pass_ret = pass_tx ? rdata_q.ret - RetW'(1) : rdata_q.ret;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swre_pkg::ST_IDLE: begin
        if (start) begin
          case (swre_pkg::cmd_e'(cmd_i))
            swre_pkg::CMD_TIMER: state_d = swre_pkg::ST_PASS_RD;
            swre_pkg::CMD_ACK:   state_d = swre_pkg::ST_ACK_RD;
            default:             state_d = swre_pkg::ST_DONE;
          endcase
        end
      end
      swre_pkg::ST_ACK_RD: begin
        state_d = (count_q == '0) ? swre_pkg::ST_DONE : swre_pkg::ST_ACK_CHK;
      end
      swre_pkg::ST_ACK_CHK: begin
        if (in_win({1'b0, rdata_q.seq}, a_hi[SeqW-1:0], seq_in_q)) begin
          state_d = swre_pkg::ST_ACK_RD;
        end else begin
          state_d = swre_pkg::ST_PASS_RD;
        end
      end
      swre_pkg::ST_PASS_RD: begin
        state_d = (pos_q == count_q) ? swre_pkg::ST_DONE : swre_pkg::ST_PASS_PROC;
      end
      swre_pkg::ST_PASS_PROC: begin
        state_d = (pass_tx && pass_ret == '0) ? swre_pkg::ST_PASS_GIVEUP
                                              : swre_pkg::ST_PASS_RD;
      end
      swre_pkg::ST_PASS_GIVEUP: state_d = swre_pkg::ST_PASS_RD;
      swre_pkg::ST_DONE:        state_d = swre_pkg::ST_IDLE;
      default:                  state_d = swre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      seq_in_q <= seq_in_i;
    end
  end

  // datapath, memory control and results
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    next_seq_d = next_seq_q;
    exp_d      = exp_q;
    scale_d    = scale_q;
    pos_d      = pos_q;
    kept_d     = kept_q;
    writes_d   = writes_q;
    ent_d      = ent_q;
    cmd_d      = cmd_q;
    fin_d      = fin_q;
    res_d      = '0;
    mem_we     = 1'b0;
    mem_waddr  = wrap_idx(head_q, kept_q);
    mem_wdata  = '0;
    mem_raddr  = wrap_idx(head_q, pos_q);

    case (state_q)
      swre_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d    = cmd_i;
          fin_d    = '0;
          pos_d    = '0;
          kept_d   = '0;
          writes_d = '0;
          case (swre_pkg::cmd_e'(cmd_i))
            swre_pkg::CMD_SEND: begin
              if (count_q == CntW'(QueueDepth)) begin
                fin_d.full = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = wrap_idx(head_q, count_q);
                mem_wdata  = '{seq: next_seq_q, tag: msg_tag_i, ret: max_ret_q};
                next_seq_d = (next_seq_q == SeqW'(SeqMod - 1)) ? '0
                                                               : next_seq_q + SeqW'(1);
                count_d    = count_q + CntW'(1);
                if ((CntW+1)'(count_q) + (CntW+1)'(1) < (CntW+1)'(Window)) begin
                  fin_d.send_arm = 1'b1;
                  res_d = '{valid: 1'b1, kind: swre_pkg::KIND_TX, seq: next_seq_q,
                            tag: msg_tag_i, default: '0};
                end
              end
            end
            swre_pkg::CMD_DATA: begin
              if (in_win(exp_q, d_hi[SeqW-1:0], seq_in_i)) begin
                fin_d.acc = 1'b1;
                scale_d   = ScaleW'(1);
                exp_d     = ExpW'(seq_in_i) + ExpW'(1);
              end else if (scale_q <= ScaleW'(ScaleInit)) begin
                scale_d = {scale_q[ScaleW-2:0], 1'b0};
              end
            end
            default: ;
          endcase
        end
      end
      swre_pkg::ST_ACK_RD: begin
        mem_raddr = head_q;
      end
      swre_pkg::ST_ACK_CHK: begin
        if (in_win({1'b0, rdata_q.seq}, a_hi[SeqW-1:0], seq_in_q)) begin
          head_d  = wrap_idx(head_q, CntW'(1));
          count_d = count_q - CntW'(1);
        end
      end
      swre_pkg::ST_PASS_RD: begin
        if (pos_q == count_q) begin
          count_d = kept_q;
        end
      end
      swre_pkg::ST_PASS_PROC: begin
        // survivors are packed in place behind head; slot head+kept is already read
        pos_d = pos_q + CntW'(1);
        ent_d = rdata_q;
        if (pass_tx) begin
          writes_d = writes_q + WinCntW'(1);
          res_d = '{valid: 1'b1, kind: swre_pkg::KIND_TX, seq: rdata_q.seq,
                    tag: rdata_q.tag, default: '0};
        end
        if (pass_ret != '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{seq: rdata_q.seq, tag: rdata_q.tag, ret: pass_ret};
          kept_d    = kept_q + CntW'(1);
        end else if (!pass_tx) begin
          res_d = '{valid: 1'b1, kind: swre_pkg::KIND_GAVE_UP, seq: rdata_q.seq,
                    tag: rdata_q.tag, default: '0};
        end
      end
      swre_pkg::ST_PASS_GIVEUP: begin
        res_d = '{valid: 1'b1, kind: swre_pkg::KIND_GAVE_UP, seq: ent_q.seq,
                  tag: ent_q.tag, default: '0};
      end
      swre_pkg::ST_DONE: begin
        res_d.valid = 1'b1;
        res_d.kind  = swre_pkg::KIND_DONE;
        res_d.last  = 1'b1;
        res_d.acc   = fin_q.acc;
        res_d.full  = fin_q.full;
        case (swre_pkg::cmd_e'(cmd_q))
          swre_pkg::CMD_SEND:  res_d.arm = fin_q.send_arm;
          swre_pkg::CMD_TIMER,
          swre_pkg::CMD_ACK:   res_d.arm = (count_q != '0);
          default:             res_d.arm = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= swre_pkg::ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      next_seq_q <= '0;
      exp_q      <= '0;
      scale_q    <= ScaleW'(ScaleInit);
      max_ret_q  <= swre_pkg::RETRY_RESET;
      pos_q      <= '0;
      kept_q     <= '0;
      writes_q   <= '0;
      cmd_q      <= '0;
      fin_q      <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      next_seq_q <= next_seq_d;
      exp_q      <= exp_d;
      scale_q    <= scale_d;
      pos_q      <= pos_d;
      kept_q     <= kept_d;
      writes_q   <= writes_d;
      cmd_q      <= cmd_d;
      fin_q      <= fin_d;
      res_q      <= res_d;
      if (cfg_we_i) begin
        max_ret_q <= (cfg_wdata_i == '0) ? RetW'(1) : cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign busy         = (state_q != swre_pkg::ST_IDLE);
  assign res_strobe_o = res_q.valid;
  assign kind_o       = res_q.kind;
  assign seq_out_o    = res_q.seq;
  assign tag_out_o    = res_q.tag;
  assign accepted_o   = res_q.acc;
  assign arm_timer_o  = res_q.arm;
  assign queue_full_o = res_q.full;
  assign last_o       = res_q.last;

endmodule

`default_nettype wire

// ===== rtl/core/swre_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swre_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       res_strobe_o,
  input wire logic [1:0] kind_o,
  input wire logic       last_o
);

  // finish word is always the last one of a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (kind_o == swre_pkg::KIND_DONE) |-> last_o)
    else $error("finish word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (kind_o != swre_pkg::KIND_DONE) |-> !last_o)
    else $error("event word marked last");

  // an event word can only show up while a command is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |-> busy)
    else $error("event word while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy)
    else $error("busy after finish word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken but engine not busy");

endmodule

bind sliding_window_retransmit_engine swre_checker u_swre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .kind_o       (kind_o),
  .last_o       (last_o)
);

`default_nettype wire

// ===== test/sliding_window_retransmit_engine_checker.sv =====
`timescale 1ns / 1ps

module sliding_window_retransmit_engine_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [1:0] cmd_i,
  input  wire logic [9:0] seq_in_i,
  input  wire logic [15:0] msg_tag_i,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       res_strobe_o,
  input  wire logic [1:0] kind_o,
  input  wire logic [9:0] seq_out_o,
  input  wire logic [15:0] tag_out_o,
  input  wire logic       accepted_o,
  input  wire logic       arm_timer_o,
  input  wire logic       queue_full_o,
  input  wire logic       last_o,
  output int              errors,
  output int              pending,
  output logic [9:0]      next_seq
);

  localparam int unsigned SeqMod   = 1024;
  localparam int unsigned Win      = 8;
  localparam int unsigned Depth    = 32;
  localparam int          DueDepth = 64;

  typedef struct {
    swre_pkg::kind_e kind;
    logic [9:0]      seq;
    logic [15:0]     tag;
    logic            acc;
    logic            arm;
    logic            full;
    logic            last;
  } word_t;

  // ring of expected words
  word_t       due_buf [DueDepth];
  int          due_rd, due_wr;
  logic [7:0]  retry_limit;
  logic [9:0]  q_seq [Depth];
  logic [15:0] q_tag [Depth];
  logic [7:0]  q_ret [Depth];
  int          q_head, q_count;
  int          rx_expect, rx_scale;

  assign pending = due_wr - due_rd;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_word(input swre_pkg::kind_e k, input logic [9:0] s,
                           input logic [15:0] t, input logic a, input logic arm,
                           input logic f, input logic l);
    word_t w;
    w.kind = k; w.seq = s; w.tag = t; w.acc = a; w.arm = arm; w.full = f; w.last = l;
    due_buf[due_wr % DueDepth] = w;
    due_wr++;
  endtask

  // walk the queue once: retransmit up to a window, drop spent entries, compact to slot 0
  task automatic retry_walk();
    logic [9:0]  ks [Depth];
    logic [15:0] kt [Depth];
    logic [7:0]  kr [Depth];
    int          sent, kept, idx;
    logic [7:0]  r;
    sent = 0;
    kept = 0;
    for (int i = 0; i < q_count; i++) begin
      idx = (q_head + i) % Depth;
      r = q_ret[idx];
      if (r > 0 && sent < Win) begin
        push_word(swre_pkg::KIND_TX, q_seq[idx], q_tag[idx], 0, 0, 0, 0);
        sent++;
        r--;
      end
      if (r > 0) begin
        ks[kept] = q_seq[idx]; kt[kept] = q_tag[idx]; kr[kept] = r;
        kept++;
      end else begin
        push_word(swre_pkg::KIND_GAVE_UP, q_seq[idx], q_tag[idx], 0, 0, 0, 0);
      end
    end
    for (int i = 0; i < kept; i++) begin
      q_seq[i] = ks[i]; q_tag[i] = kt[i]; q_ret[i] = kr[i];
    end
    q_head = 0;
    q_count = kept;
  endtask

  task automatic predict_command(input swre_pkg::cmd_e c, input logic [9:0] s,
                                 input logic [15:0] t);
    int f, b, idx;
    logic arm;
    case (c)
      swre_pkg::CMD_SEND: begin
        if (q_count >= Depth) begin
          push_word(swre_pkg::KIND_DONE, 0, 0, 0, 0, 1, 1);
        end else begin
          idx = (q_head + q_count) % Depth;
          q_seq[idx] = next_seq;
          q_tag[idx] = t;
          q_ret[idx] = retry_limit;
          q_count++;
          arm = 0;
          if (q_count < Win) begin
            push_word(swre_pkg::KIND_TX, next_seq, t, 0, 0, 0, 0);
            arm = 1;
          end
          next_seq = next_seq + 10'd1;
          push_word(swre_pkg::KIND_DONE, 0, 0, 0, arm, 0, 1);
        end
      end
      swre_pkg::CMD_TIMER: begin
        retry_walk();
        push_word(swre_pkg::KIND_DONE, 0, 0, 0, q_count > 0, 0, 1);
      end
      swre_pkg::CMD_ACK: begin
        while (q_count > 0) begin
          f = q_seq[q_head];
          b = (f + Win) % SeqMod;
          if (!(f <= s || (s < b && b < f))) break;
          q_head = (q_head + 1) % Depth;
          q_count--;
        end
        if (q_count > 0) retry_walk();
        push_word(swre_pkg::KIND_DONE, 0, 0, 0, q_count > 0, 0, 1);
      end
      default: begin
        b = (rx_expect + Win * rx_scale) % SeqMod;
        if (rx_expect <= s || (s < b && b < rx_expect)) begin
          rx_scale = 1;
          rx_expect = s + 1;
          push_word(swre_pkg::KIND_DONE, 0, 0, 1, 0, 0, 1);
        end else begin
          if (rx_scale <= SeqMod / Win) rx_scale = rx_scale * 2;
          push_word(swre_pkg::KIND_DONE, 0, 0, 0, 0, 0, 1);
        end
      end
    endcase
  endtask

  task automatic check_word();
    word_t w;
    if (due_wr == due_rd) begin
      report($sformatf("unexpected word kind=%0d seq=%0d", kind_o, seq_out_o));
      return;
    end
    w = due_buf[due_rd % DueDepth];
    due_rd++;
    if (kind_o !== w.kind)
      report($sformatf("kind %0d, want %0d", kind_o, w.kind));
    if (seq_out_o !== w.seq)
      report($sformatf("seq_out %0d, want %0d", seq_out_o, w.seq));
    if (tag_out_o !== w.tag)
      report($sformatf("tag_out %h, want %h", tag_out_o, w.tag));
    if (accepted_o !== w.acc)
      report($sformatf("accepted %b, want %b", accepted_o, w.acc));
    if (arm_timer_o !== w.arm)
      report($sformatf("arm_timer %b, want %b", arm_timer_o, w.arm));
    if (queue_full_o !== w.full)
      report($sformatf("queue_full %b, want %b", queue_full_o, w.full));
    if (last_o !== w.last)
      report($sformatf("last %b, want %b", last_o, w.last));
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_rd = 0;
      due_wr = 0;
      retry_limit <= swre_pkg::RETRY_RESET;
      q_head = 0;
      q_count = 0;
      next_seq = '0;
      rx_expect = 0;
      rx_scale = SeqMod / Win;
    end else begin
      if (res_strobe_o) check_word();
      if (cfg_we_i) retry_limit <= (cfg_wdata_i == 0) ? 8'd1 : cfg_wdata_i;
      if (start && !busy) predict_command(swre_pkg::cmd_e'(cmd_i), seq_in_i, msg_tag_i);
    end
  end

endmodule

// ===== test/sliding_window_retransmit_engine_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_retransmit_engine_tb;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  cmd_i = '0;
  logic [9:0]  seq_in_i = '0;
  logic [15:0] msg_tag_i = '0;
  logic        cfg_we_i = 0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        res_strobe_o, accepted_o, arm_timer_o, queue_full_o, last_o;
  logic [1:0]  kind_o;
  logic [9:0]  seq_out_o, next_seq;
  logic [15:0] tag_out_o;
  int          errors, pending;
  bit          no_gaps;
  logic [9:0]  rx_seq;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  sliding_window_retransmit_engine uut (.*);

  sliding_window_retransmit_engine_checker chk (.*);

  task automatic issue(input swre_pkg::cmd_e c, input logic [9:0] s, input logic [15:0] t);
    if (!no_gaps) begin
      while ($urandom_range(99) < 17) begin
        start <= 0;
        @(posedge clk_i);
      end
    end
    start <= 1;
    cmd_i <= c;
    seq_in_i <= s;
    msg_tag_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // config only while idle; every command ends in a finish word
  task automatic set_retries(input logic [7:0] v);
    start <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(input int n, input int send_pct);
    int r;
    logic [9:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < send_pct) begin
        issue(swre_pkg::CMD_SEND, 10'($urandom), 16'($urandom));
      end else if (r < send_pct + (100 - send_pct) / 3) begin
        issue(swre_pkg::CMD_TIMER, 10'($urandom), 16'($urandom));
      end else if (r < send_pct + 2 * (100 - send_pct) / 3) begin
        // acks mostly land just behind the send pointer
        s = ($urandom_range(9) == 0) ? 10'($urandom) : next_seq - 10'($urandom_range(14));
        issue(swre_pkg::CMD_ACK, s, 16'($urandom));
      end else begin
        s = ($urandom_range(2) == 0) ? 10'($urandom) : rx_seq;
        rx_seq = s + 10'd1;
        issue(swre_pkg::CMD_DATA, s, 16'($urandom));
      end
    end
  endtask

  initial begin
    no_gaps = 0;
    rx_seq = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: data window extremes, send/ack/timer at reset retry limit
    issue(swre_pkg::CMD_DATA, 10'd1023, 16'hffff);
    issue(swre_pkg::CMD_DATA, 10'd0, 16'h0000);
    issue(swre_pkg::CMD_DATA, 10'd500, 16'h0);
    issue(swre_pkg::CMD_DATA, 10'd2, 16'h0);
    issue(swre_pkg::CMD_DATA, 10'd1, 16'h0);
    issue(swre_pkg::CMD_TIMER, 10'd0, 16'h0);
    issue(swre_pkg::CMD_ACK, 10'd1023, 16'h0);
    for (int i = 0; i < 10; i++)
      issue(swre_pkg::CMD_SEND, 10'd0, (i % 2) ? 16'hffff : 16'h0000);
    issue(swre_pkg::CMD_TIMER, 10'd0, 16'h0);
    issue(swre_pkg::CMD_ACK, 10'd3, 16'h0);
    issue(swre_pkg::CMD_ACK, 10'd1023, 16'h0);
    issue(swre_pkg::CMD_ACK, 10'd9, 16'h0);
    // limit write of zero behaves as one: retransmit and give up in one pass
    set_retries(8'd0);
    for (int i = 0; i < 3; i++) issue(swre_pkg::CMD_SEND, 10'd0, 16'h1234);
    issue(swre_pkg::CMD_TIMER, 10'd0, 16'h0);

    set_retries(8'd255);
    random_phase(45, 80);   // pushes the queue to full
    set_retries(8'd1);
    no_gaps = 1;
    random_phase(25, 45);
    no_gaps = 0;
    set_retries(8'd3);
    random_phase(30, 45);
    set_retries(8'd100);
    random_phase(25, 40);

    start <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("sliding_window_retransmit_engine_tb passed");
    else
      $display("sliding_window_retransmit_engine_tb failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("sliding_window_retransmit_engine_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/swre_pkg.sv
rtl/core/sliding_window_retransmit_engine.sv
rtl/core/swre_checker.sv
test/sliding_window_retransmit_engine_checker.sv
test/sliding_window_retransmit_engine_tb.sv
